[sv/psu_pkg.sv]
package psu_pkg;

	localparam int COMP_BITS  = 16;
	localparam int FRAC_BITS  = 8;
	localparam int LIFE_BITS  = 16;
	localparam int NUM_COMP   = 3;
	localparam int VEC_BITS   = NUM_COMP * COMP_BITS;
	localparam int NUM_CHAN   = 4;
	localparam int CH_BITS    = 8;
	localparam int COLOR_BITS = NUM_CHAN * CH_BITS;
	// rate (signed) times step (unsigned, one extra bit for sign)
	localparam int PROD_BITS  = COMP_BITS + LIFE_BITS + 1;
	localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
	localparam int SUM_BITS   = SHIFT_BITS + 1;
	// lerp numerator magnitude: |e - s| * |total - life|
	localparam int NUM_BITS   = CH_BITS + LIFE_BITS;
	localparam int DIV_STAGES = 3;
	localparam int DIV_STEP   = NUM_BITS / DIV_STAGES;
	localparam int CSUM_BITS  = NUM_BITS + 2;

	typedef logic [COMP_BITS-1:0] comp_t;
	typedef logic signed [SHIFT_BITS-1:0] delta_t;

	typedef struct packed {
		logic [LIFE_BITS-1:0]  delta_time;
		logic [LIFE_BITS-1:0]  life_left;
		logic [LIFE_BITS-1:0]  life_total;
		logic [COLOR_BITS-1:0] color_start;
		logic [COLOR_BITS-1:0] color_end;
		logic [VEC_BITS-1:0]   size_vec;
		logic [VEC_BITS-1:0]   size_rate;
		logic [VEC_BITS-1:0]   vel_vec;
		logic [VEC_BITS-1:0]   accel_vec;
		logic [VEC_BITS-1:0]   pos_vec;
		logic [VEC_BITS-1:0]   angle_vec;
		logic [VEC_BITS-1:0]   spin_vec;
	} in_item_t;

	typedef struct packed {
		logic                  alive;
		logic [LIFE_BITS-1:0]  life_out;
		logic [COLOR_BITS-1:0] color_out;
		logic [VEC_BITS-1:0]   size_out;
		logic [VEC_BITS-1:0]   vel_out;
		logic [VEC_BITS-1:0]   pos_out;
		logic [VEC_BITS-1:0]   angle_out;
	} out_item_t;

	typedef struct packed {
		logic [LIFE_BITS-1:0] rem;
		logic [DIV_STEP-1:0]  quo;
	} div_part_t;

	// floor(rate * dt / 2^FRAC_BITS)
	function automatic delta_t scaled(comp_t rate, logic [LIFE_BITS-1:0] dt);
		logic signed [PROD_BITS-1:0] p;
		p = $signed(rate) * $signed({1'b0, dt});
		return p[PROD_BITS-1:FRAC_BITS];
	endfunction

	function automatic comp_t sat_add(comp_t base, delta_t d);
		logic signed [SUM_BITS-1:0] s;
		s = $signed(base) + d;
		if ((&s[SUM_BITS-1:COMP_BITS-1]) || (~|s[SUM_BITS-1:COMP_BITS-1]))
			return s[COMP_BITS-1:0];
		else if (s[SUM_BITS-1])
			return {1'b1, {(COMP_BITS-1){1'b0}}};
		else
			return {1'b0, {(COMP_BITS-1){1'b1}}};
	endfunction

	// restoring division, DIV_STEP quotient bits
	function automatic div_part_t div_step(logic [LIFE_BITS-1:0] rem,
			logic [DIV_STEP-1:0] bits, logic [LIFE_BITS-1:0] dvsr);
		logic [LIFE_BITS:0] r;
		div_part_t res;
		res.rem = rem;
		res.quo = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			r = {res.rem, bits[i]};
			if (r >= {1'b0, dvsr}) begin
				r = r - {1'b0, dvsr};
				res.quo[i] = 1'b1;
			end
			res.rem = r[LIFE_BITS-1:0];
		end
		return res;
	endfunction

endpackage

[sv/psu_in_if.sv]
interface psu_in_if;
	logic               valid;
	logic               ready;
	psu_pkg::in_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/psu_out_if.sv]
interface psu_out_if;
	logic               valid;
	logic               ready;
	psu_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/particle_state_update_core.sv]
// One Euler step per particle in Q8.8 fixed point, one transaction in and one
// out per particle. Six register stages: input register, products, velocity
// and first quotient byte, position product, position sum and last quotient
// byte, output register. A new particle is taken every cycle unless update.ready
// stalls the pipeline; an accepted particle passes each stage in turn, and its
// result is valid from the output register. The color lerp divides by the start
// lifetime in a restoring divider spread over three stages, eight quotient bits
// each. Expired particles come out with alive low, life and color zero and the vectors unchanged.
module particle_state_update_core (
	input  logic      clk,
	input  logic      arst_n,
	psu_in_if.sink    particle,
	psu_out_if.source update
);

	localparam int CB = psu_pkg::COMP_BITS;
	localparam int LB = psu_pkg::LIFE_BITS;
	localparam int NC = psu_pkg::NUM_COMP;
	localparam int NCH = psu_pkg::NUM_CHAN;
	localparam int CHB = psu_pkg::CH_BITS;
	localparam int NB = psu_pkg::NUM_BITS;
	localparam int DS = psu_pkg::DIV_STEP;
	localparam int CSB = psu_pkg::CSUM_BITS;

	logic [6:1] adv;
	logic [6:1] v_s;

	// stage 1: input register
	psu_pkg::in_item_t in_s1;

	// stage 2
	logic                   dead_s2;
	logic [LB-1:0]          life_s2, total_s2, dt_s2;
	logic [psu_pkg::COLOR_BITS-1:0] cs_s2;
	logic [NB-1:0]          num_s2 [NCH];
	logic [NCH-1:0]         neg_s2;
	logic [psu_pkg::VEC_BITS-1:0] size_s2, vel_s2, pos_s2, ang_s2;
	psu_pkg::delta_t        dsize_s2 [NC], dvel_s2 [NC], dang_s2 [NC];

	// stage 3
	logic                   dead_s3;
	logic [LB-1:0]          life_s3, total_s3, dt_s3;
	logic [psu_pkg::COLOR_BITS-1:0] cs_s3;
	logic [NB-1:0]          num_s3 [NCH];
	logic [NCH-1:0]         neg_s3;
	logic [LB-1:0]          rem_s3 [NCH];
	logic [DS-1:0]          qhi_s3 [NCH];
	logic [psu_pkg::VEC_BITS-1:0] size_s3, vel_s3, pos_s3, ang_s3;

	// stage 4
	logic                   dead_s4;
	logic [LB-1:0]          life_s4, total_s4;
	logic [psu_pkg::COLOR_BITS-1:0] cs_s4;
	logic [NB-1:0]          num_s4 [NCH];
	logic [NCH-1:0]         neg_s4;
	logic [LB-1:0]          rem_s4 [NCH];
	logic [2*DS-1:0]        qhi_s4 [NCH];
	logic [psu_pkg::VEC_BITS-1:0] size_s4, vel_s4, pos_s4, ang_s4;
	psu_pkg::delta_t        dpos_s4 [NC];

	// stage 5
	logic                   dead_s5;
	logic [LB-1:0]          life_s5, total_s5;
	logic [psu_pkg::COLOR_BITS-1:0] cs_s5, ce_s2, ce_s3, ce_s4, ce_s5;
	logic [NCH-1:0]         neg_s5;
	logic [NB-1:0]          quo_s5 [NCH];
	logic [psu_pkg::VEC_BITS-1:0] size_s5, vel_s5, pos_s5, ang_s5;

	// stage 6: output register
	psu_pkg::out_item_t     out_s6;

	// a stage moves when empty or when the next one moves
	assign adv[6] = !v_s[6] || update.ready;
	assign adv[5] = !v_s[5] || adv[6];
	assign adv[4] = !v_s[4] || adv[5];
	assign adv[3] = !v_s[3] || adv[4];
	assign adv[2] = !v_s[2] || adv[3];
	assign adv[1] = !v_s[1] || adv[2];

	assign particle.ready = adv[1];
	assign update.valid   = v_s[6];
	assign update.data    = out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv[1]) v_s[1] <= particle.valid;
			for (int i = 2; i <= 6; i++)
				if (adv[i]) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1] && particle.valid)
			in_s1 <= particle.data;
	end

	// stage 1 -> 2: lifetime, lerp numerator, integration products
	logic [LB:0]    life1;
	logic [LB:0]    tl1;
	logic [LB-1:0]  tmag1;
	logic [CHB:0]   diff1 [NCH];
	logic [CHB-1:0] dmag1 [NCH];

	always_comb begin
		life1 = {1'b0, in_s1.life_left} - {1'b0, in_s1.delta_time};
		tl1   = {1'b0, in_s1.life_total} - {1'b0, life1[LB-1:0]};
		tmag1 = tl1[LB] ? LB'(-tl1) : tl1[LB-1:0];
		for (int k = 0; k < NCH; k++) begin
			diff1[k] = {1'b0, in_s1.color_end[k*CHB +: CHB]}
				- {1'b0, in_s1.color_start[k*CHB +: CHB]};
			dmag1[k] = diff1[k][CHB] ? CHB'(-diff1[k]) : diff1[k][CHB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2] && v_s[1]) begin
			dead_s2  <= life1[LB];
			life_s2  <= life1[LB-1:0];
			total_s2 <= in_s1.life_total;
			dt_s2    <= in_s1.delta_time;
			cs_s2    <= in_s1.color_start;
			ce_s2    <= in_s1.color_end;
			size_s2  <= in_s1.size_vec;
			vel_s2   <= in_s1.vel_vec;
			pos_s2   <= in_s1.pos_vec;
			ang_s2   <= in_s1.angle_vec;
			for (int k = 0; k < NCH; k++) begin
				num_s2[k] <= dmag1[k] * tmag1;
				neg_s2[k] <= diff1[k][CHB] ^ tl1[LB];
			end
			for (int c = 0; c < NC; c++) begin
				dsize_s2[c] <= psu_pkg::scaled(in_s1.size_rate[c*CB +: CB], in_s1.delta_time);
				dvel_s2[c]  <= psu_pkg::scaled(in_s1.accel_vec[c*CB +: CB], in_s1.delta_time);
				dang_s2[c]  <= psu_pkg::scaled(in_s1.spin_vec[c*CB +: CB], in_s1.delta_time);
			end
		end
	end

	// stage 2 -> 3: size, velocity, rotation sums; top quotient bits
	psu_pkg::div_part_t dp2 [NCH];
	logic [psu_pkg::VEC_BITS-1:0] size2, vel2, ang2;

	always_comb begin
		for (int k = 0; k < NCH; k++)
			dp2[k] = psu_pkg::div_step('0, num_s2[k][NB-1 -: DS], total_s2);
		for (int c = 0; c < NC; c++) begin
			size2[c*CB +: CB] = psu_pkg::sat_add(size_s2[c*CB +: CB], dsize_s2[c]);
			vel2[c*CB +: CB]  = psu_pkg::sat_add(vel_s2[c*CB +: CB], dvel_s2[c]);
			ang2[c*CB +: CB]  = psu_pkg::sat_add(ang_s2[c*CB +: CB], dang_s2[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3] && v_s[2]) begin
			dead_s3  <= dead_s2;
			life_s3  <= life_s2;
			total_s3 <= total_s2;
			dt_s3    <= dt_s2;
			cs_s3    <= cs_s2;
			ce_s3    <= ce_s2;
			neg_s3   <= neg_s2;
			pos_s3   <= pos_s2;
			// expired particles keep their state
			size_s3  <= dead_s2 ? size_s2 : size2;
			vel_s3   <= dead_s2 ? vel_s2 : vel2;
			ang_s3   <= dead_s2 ? ang_s2 : ang2;
			for (int k = 0; k < NCH; k++) begin
				num_s3[k] <= num_s2[k];
				rem_s3[k] <= dp2[k].rem;
				qhi_s3[k] <= dp2[k].quo;
			end
		end
	end

	// stage 3 -> 4: position product from the new velocity; middle quotient bits
	psu_pkg::div_part_t dp3 [NCH];

	always_comb begin
		for (int k = 0; k < NCH; k++)
			dp3[k] = psu_pkg::div_step(rem_s3[k], num_s3[k][NB-DS-1 -: DS], total_s3);
	end

	always_ff @(posedge clk) begin
		if (adv[4] && v_s[3]) begin
			dead_s4  <= dead_s3;
			life_s4  <= life_s3;
			total_s4 <= total_s3;
			cs_s4    <= cs_s3;
			ce_s4    <= ce_s3;
			neg_s4   <= neg_s3;
			size_s4  <= size_s3;
			vel_s4   <= vel_s3;
			pos_s4   <= pos_s3;
			ang_s4   <= ang_s3;
			for (int k = 0; k < NCH; k++) begin
				num_s4[k] <= num_s3[k];
				rem_s4[k] <= dp3[k].rem;
				qhi_s4[k] <= {qhi_s3[k], dp3[k].quo};
			end
			for (int c = 0; c < NC; c++)
				dpos_s4[c] <= psu_pkg::scaled(vel_s3[c*CB +: CB], dt_s3);
		end
	end

	// stage 4 -> 5: position sum; last quotient bits
	psu_pkg::div_part_t dp4 [NCH];
	logic [psu_pkg::VEC_BITS-1:0] pos4;

	always_comb begin
		for (int k = 0; k < NCH; k++)
			dp4[k] = psu_pkg::div_step(rem_s4[k], num_s4[k][DS-1:0], total_s4);
		for (int c = 0; c < NC; c++)
			pos4[c*CB +: CB] = psu_pkg::sat_add(pos_s4[c*CB +: CB], dpos_s4[c]);
	end

	always_ff @(posedge clk) begin
		if (adv[5] && v_s[4]) begin
			dead_s5  <= dead_s4;
			life_s5  <= life_s4;
			total_s5 <= total_s4;
			cs_s5    <= cs_s4;
			ce_s5    <= ce_s4;
			neg_s5   <= neg_s4;
			size_s5  <= size_s4;
			vel_s5   <= vel_s4;
			pos_s5   <= dead_s4 ? pos_s4 : pos4;
			ang_s5   <= ang_s4;
			for (int k = 0; k < NCH; k++)
				quo_s5[k] <= NB'({qhi_s4[k], dp4[k].quo});
		end
	end

	// stage 5 -> 6: signed quotient added to start color, clamped; end color if total life is zero
	logic signed [CSB-1:0] csum5 [NCH];
	logic [psu_pkg::COLOR_BITS-1:0] color5;

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			csum5[k] = $signed({{(CSB-CHB){1'b0}}, cs_s5[k*CHB +: CHB]})
				+ (neg_s5[k] ? -$signed({2'b00, quo_s5[k]}) : $signed({2'b00, quo_s5[k]}));
			if (total_s5 == '0)
				color5[k*CHB +: CHB] = ce_s5[k*CHB +: CHB];
			else if (csum5[k][CSB-1])
				color5[k*CHB +: CHB] = '0;
			else if (|csum5[k][CSB-2:CHB])
				color5[k*CHB +: CHB] = '1;
			else
				color5[k*CHB +: CHB] = csum5[k][CHB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6] && v_s[5]) begin
			out_s6.alive     <= !dead_s5;
			out_s6.life_out  <= dead_s5 ? '0 : life_s5;
			out_s6.color_out <= dead_s5 ? '0 : color5;
			out_s6.size_out  <= size_s5;
			out_s6.vel_out   <= vel_s5;
			out_s6.pos_out   <= pos_s5;
			out_s6.angle_out <= ang_s5;
		end
	end

endmodule
